### hw/rtl/ffwa_pkg.sv
// ----------------------------------------------------------------------------
// ffwa_pkg: shared types for the first-fit wavelength allocator
// Holds the transaction payloads, the command and status codes, the link
// record passed between wavelength cells and the per-user counter word.
// ----------------------------------------------------------------------------
package ffwa_pkg;

  localparam int COUNT_W  = 32;
  localparam int WL_IDX_W = 6;   // wide enough for the largest wavelength table
  localparam int ROUTE_W  = 32;
  localparam int USER_W   = 8;
  localparam int WL_W     = 4;
  localparam int WL_CFG_W = 5;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic {
    CMD_ARRIVAL   = 1'b0,
    CMD_DEPARTURE = 1'b1
  } ffwa_cmd_e;

  typedef enum logic [1:0] {
    ST_ASSIGNED = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_RELEASED = 2'd2
  } ffwa_status_e;

  // Request transaction
  typedef struct packed {
    ffwa_cmd_e            command;
    logic [USER_W-1:0]    user_id;
    logic [ROUTE_W-1:0]   route_mask;
    logic [WL_W-1:0]      wavelength;
  } ffwa_req_t;

  // Response transaction
  typedef struct packed {
    ffwa_status_e         status;
    logic [WL_W-1:0]      assigned_wavelength;
    logic [COUNT_W-1:0]   arrivals_so_far;
    logic [COUNT_W-1:0]   total_blocked;
    logic [COUNT_W-1:0]   user_arrivals;
    logic [COUNT_W-1:0]   user_blocks;
  } ffwa_rsp_t;

  // Control broadcast to every wavelength cell
  typedef struct packed {
    logic                 go;        // commit the update this cycle
    ffwa_cmd_e            command;
    logic [WL_W-1:0]      wavelength;
    logic [WL_CFG_W-1:0]  wl_limit;
  } ffwa_cell_ctrl_t;

  // Record rippling from lower to higher wavelength cells
  typedef struct packed {
    logic                 found;
    logic [WL_IDX_W-1:0]  index;
  } ffwa_chain_t;

  // One word of the per-user counter memory
  typedef struct packed {
    logic [COUNT_W-1:0]   arrivals;
    logic [COUNT_W-1:0]   blocks;
  } ffwa_counts_t;

endpackage

### hw/rtl/ffwa_cell.sv
// ----------------------------------------------------------------------------
// ffwa_cell: one wavelength cell
// Holds the link occupancy of one wavelength, tests the route for a fit and
// passes the first-fit record on to the next cell of the row.
// ----------------------------------------------------------------------------
module ffwa_cell import ffwa_pkg::*; #(
  parameter int LinkW = 32,
  parameter int Index = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ffwa_cell_ctrl_t ctrl_i,
  input  logic [LinkW-1:0] route_i,
  input  ffwa_chain_t     chain_i,
  output ffwa_chain_t     chain_o
);

  logic [LinkW-1:0] occ_q, occ_d;
  logic in_range, fit, take, release_sel;

  // Test this wavelength against the route
  assign in_range    = int'(ctrl_i.wl_limit) > Index;
  assign fit         = in_range && ((occ_q & route_i) == '0);
  assign release_sel = int'(ctrl_i.wavelength) == Index;
  assign take        = ctrl_i.go && (ctrl_i.command == CMD_ARRIVAL) && fit && !chain_i.found;

  // Pass the first fit on, keep a lower one if already found
  assign chain_o.found = chain_i.found | fit;
  assign chain_o.index = chain_i.found ? chain_i.index : WL_IDX_W'(Index);

  // Mark links busy on a grant, clear them on a release
  always_comb begin
    occ_d = occ_q;
    if (take) begin
      occ_d = occ_q | route_i;
    end else if (ctrl_i.go && (ctrl_i.command == CMD_DEPARTURE) && release_sel) begin
      occ_d = occ_q & ~route_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_d;
    end
  end

endmodule

### hw/rtl/ffwa_user_ram.sv
// ----------------------------------------------------------------------------
// ffwa_user_ram: per-user counter memory
// One write and one registered read port. A valid bit per entry, cleared at
// reset, makes an entry never written read as zero counts.
// ----------------------------------------------------------------------------
module ffwa_user_ram import ffwa_pkg::*; #(
  parameter int Depth = 256,
  parameter int Aw    = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            rd_en_i,
  input  logic [Aw-1:0]   rd_addr_i,
  output ffwa_counts_t    rd_data_o,
  input  logic            wr_en_i,
  input  logic [Aw-1:0]   wr_addr_i,
  input  ffwa_counts_t    wr_data_i
);

  ffwa_counts_t mem [Depth];
  ffwa_counts_t rd_data_q;
  logic [Depth-1:0] vld_q;
  logic rd_vld_q;

  // Store the counter word
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  // Track written entries and the validity of the read word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

### hw/rtl/first_fit_wavelength_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_wavelength_allocator_core: first-fit wavelength allocator
// Usage:
//   Requests enter on req_valid_i/req_ready_o with an ffwa_req_t payload.
//   An arrival takes the lowest permitted wavelength whose links on the route
//   are all free and marks them busy, or reports blocked; a departure clears
//   the route's links on the given wavelength.
//   Responses leave on rsp_valid_o/rsp_ready_i with an ffwa_rsp_t payload,
//   one per request, carrying the saturating global and per-user counters.
//   cfg_we_i writes the permitted wavelength count (cfg_wdata_i) at once.
// Flow:
//   A request is taken in IDLE (per-user counter read) and resolved in EXEC
//   (first-fit ripple across the row of wavelength cells, counter write-back),
//   which stalls while the response register is full. The response is
//   registered at resolution; no new request is accepted until then.
// Reset:
//   All links free, all counters zero, permitted count 16; no clearing pass.
// Back-pressure:
//   A waiting response does not block acceptance; a request resolving while
//   the response register is still full holds until rsp_ready_i.
// ----------------------------------------------------------------------------
module first_fit_wavelength_allocator_core import ffwa_pkg::*; #(
  parameter int NUM_WAVELENGTHS = 16,
  parameter int NUM_LINKS       = 32,
  parameter int NUM_USERS       = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  ffwa_req_t           req_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output ffwa_rsp_t           rsp_o,
  input  logic                cfg_we_i,
  input  logic [WL_CFG_W-1:0] cfg_wdata_i
);

  localparam int LinkW     = (NUM_LINKS < ROUTE_W) ? NUM_LINKS : ROUTE_W;
  localparam int UserDepth = (NUM_USERS < (1 << USER_W)) ? NUM_USERS : (1 << USER_W);
  localparam int UserAw    = (UserDepth > 1) ? $clog2(UserDepth) : 1;

  typedef enum logic {
    IDLE,
    EXEC
  } state_e;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
  endfunction

  state_e              state_q;
  ffwa_req_t           req_q;
  ffwa_rsp_t           rsp_q, rsp_d;
  logic                rsp_valid_q;
  logic [WL_CFG_W-1:0] wl_in_use_q;
  logic [COUNT_W-1:0]  total_arr_q, total_arr_d;
  logic [COUNT_W-1:0]  total_blk_q, total_blk_d;

  logic                accept, advance, is_arrival, found;
  logic                user_ok_in, user_ok_q;
  ffwa_counts_t        user_rd, user_wr;
  ffwa_cell_ctrl_t     cell_ctrl;
  ffwa_chain_t         chain [NUM_WAVELENGTHS+1];

  assign req_ready_o = (state_q == IDLE);
  assign accept      = req_valid_i && req_ready_o;
  assign advance     = (state_q == EXEC) && (!rsp_valid_q || rsp_ready_i);
  assign is_arrival  = (req_q.command == CMD_ARRIVAL);
  assign user_ok_in  = int'(req_i.user_id) < NUM_USERS;
  assign user_ok_q   = int'(req_q.user_id) < NUM_USERS;

  // Per-user counters: read on acceptance, write back on resolution
  ffwa_user_ram #(
    .Depth (UserDepth),
    .Aw    (UserAw)
  ) u_user_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept && user_ok_in),
    .rd_addr_i (req_i.user_id[UserAw-1:0]),
    .rd_data_o (user_rd),
    .wr_en_i   (advance && is_arrival && user_ok_q),
    .wr_addr_i (req_q.user_id[UserAw-1:0]),
    .wr_data_i (user_wr)
  );

  // Broadcast the request to the cell row
  assign cell_ctrl.go         = advance;
  assign cell_ctrl.command    = req_q.command;
  assign cell_ctrl.wavelength = req_q.wavelength;
  assign cell_ctrl.wl_limit   = wl_in_use_q;

  assign chain[0] = '0;

  for (genvar w = 0; w < NUM_WAVELENGTHS; w++) begin : g_cell
    ffwa_cell #(
      .LinkW (LinkW),
      .Index (w)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (cell_ctrl),
      .route_i (req_q.route_mask[LinkW-1:0]),
      .chain_i (chain[w]),
      .chain_o (chain[w+1])
    );
  end

  assign found = chain[NUM_WAVELENGTHS].found;

  // Update counters and build the response
  always_comb begin
    total_arr_d      = total_arr_q;
    total_blk_d      = total_blk_q;
    user_wr          = user_rd;
    rsp_d            = '0;
    rsp_d.status     = ST_RELEASED;
    if (is_arrival) begin
      total_arr_d      = sat_inc(total_arr_q);
      user_wr.arrivals = sat_inc(user_rd.arrivals);
      if (found) begin
        rsp_d.status              = ST_ASSIGNED;
        rsp_d.assigned_wavelength = chain[NUM_WAVELENGTHS].index[WL_W-1:0];
      end else begin
        rsp_d.status  = ST_BLOCKED;
        total_blk_d   = sat_inc(total_blk_q);
        user_wr.blocks = sat_inc(user_rd.blocks);
      end
    end
    rsp_d.arrivals_so_far = total_arr_d;
    rsp_d.total_blocked   = total_blk_d;
    rsp_d.user_arrivals   = user_ok_q ? user_wr.arrivals : '0;
    rsp_d.user_blocks     = user_ok_q ? user_wr.blocks : '0;
  end

  // Hold state, counters and the response handshake
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= IDLE;
      rsp_valid_q <= 1'b0;
      wl_in_use_q <= WL_CFG_W'(16);
      total_arr_q <= '0;
      total_blk_q <= '0;
    end else begin
      if (cfg_we_i) begin
        wl_in_use_q <= cfg_wdata_i;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_valid_q && rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
      case (state_q)
        IDLE: begin
          if (accept) begin
            state_q <= EXEC;
          end
        end
        EXEC: begin
          if (advance) begin
            state_q     <= IDLE;
            total_arr_q <= total_arr_d;
            total_blk_q <= total_blk_d;
          end
        end
        default: begin
          state_q <= IDLE;
        end
      endcase
    end
  end

  // Capture payloads
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // A transaction taken closes the request side for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !req_ready_o)
    else $error("request accepted while the previous one was resolving");

  // A departure always reports a release
  a_departure_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !is_arrival) |=> (rsp_o.status == ST_RELEASED && rsp_valid_o))
    else $error("departure did not report a release");

  // Blocked arrivals never outnumber arrivals
  a_blocked_le_arrivals: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_blk_q <= total_arr_q)
    else $error("blocked count exceeds arrival count");

  // A grant only goes to a permitted wavelength
  a_grant_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_arrival && found) |->
      (int'(chain[NUM_WAVELENGTHS].index) < int'(wl_in_use_q)))
    else $error("wavelength granted beyond the permitted count");

endmodule
